/* hdl/page_reference_counter_table_unit_macros.svh */
// Assertion macros shared by the page reference count table modules.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef PAGE_REFERENCE_COUNTER_TABLE_UNIT_MACROS_SVH
`define PAGE_REFERENCE_COUNTER_TABLE_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PRCT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PRCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/prct_pkg.sv */
// Types, constants and codes shared by the page reference count table.
// No dependencies.
`timescale 1ns / 1ps

package prct_pkg;

    localparam int PAGE_COUNT = 8192;
    localparam int PAGE_SHIFT = 12;
    localparam int FRAME_W = $clog2(PAGE_COUNT);
    localparam int ADDR_W = 48;
    localparam int COUNT_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [ADDR_W-1:0] RAM_BASE_RST = 48'd0;
    localparam logic [ADDR_W-1:0] RAM_END_RST = 48'd33554432;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAM_BASE = 1'b0,
        CFG_RAM_END  = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CMD_SET     = 2'd0,
        CMD_GET     = 2'd1,
        CMD_ACQUIRE = 2'd2,
        CMD_RELEASE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ADDR  = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'd0,
        BK_FETCH = 2'd1,
        BK_EXEC  = 2'd2
    } back_state_t;

    typedef struct packed {
        cmd_t               cmd;
        logic               bad;
        logic [FRAME_W-1:0] frame;
        logic [COUNT_W-1:0] new_count;
    } req_t;

endpackage

/* hdl/page_reference_counter_table_unit.sv */
// Top level of the page reference count table: front end, request queue and back end.
// Depends on prct_pkg, prct_front, prct_fifo and prct_back.
//
//   Channel   Direction  Handshake            Contents
//   s_        in         s_tvalid / s_tready  command, physical address, new count
//   m_        out        m_tvalid / m_tready  status, count, page freed
//   cfg_      in         cfg_we               ram_base (index 0), ram_end (index 1)
//
// The back end handles one request at a time: it reads the count memory in the fetch
// state, then updates it and loads the result register in the exec state.
// After reset a clearing pass writes zero to all 8192 entries, one per cycle;
// s_tready stays low until the pass ends. A stalled result holds the back end,
// and a full four-entry queue then holds s_tready low.
`timescale 1ns / 1ps

module page_reference_counter_table_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [prct_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [prct_pkg::ADDR_W-1:0]        cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // phys_addr [47:0], new_count [63:48]
    input  logic [63:0]                        s_tdata,
    // command [1:0]
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // status [1:0], count [17:2], page_freed [18], zero fill [23:19]
    output logic [23:0]                        m_tdata
);

    prct_pkg::req_t               q_wdata;
    prct_pkg::req_t               q_rdata;
    logic                         q_push;
    logic                         q_pop;
    logic                         q_full;
    logic                         q_empty;
    logic                         clear_busy;
    logic [1:0]                   res_status;
    logic [prct_pkg::COUNT_W-1:0] res_count;
    logic                         res_freed;

    prct_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_cmd       (s_tuser),
        .s_addr      (s_tdata[47:0]),
        .s_new_count (s_tdata[63:48]),
        .clear_busy  (clear_busy),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_wdata     (q_wdata)
    );

    prct_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    prct_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_rdata      (q_rdata),
        .q_pop        (q_pop),
        .clear_busy   (clear_busy),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_status     (res_status),
        .m_count      (res_count),
        .m_page_freed (res_freed)
    );

    assign m_tdata = {5'b0, res_freed, res_count, res_status};

endmodule

/* hdl/prct_front.sv */
// Front end: holds the address window registers and classifies each request.
// Depends on prct_pkg.
`timescale 1ns / 1ps

module prct_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [prct_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [prct_pkg::ADDR_W-1:0]        cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [1:0]                         s_cmd,
    input  logic [prct_pkg::ADDR_W-1:0]        s_addr,
    input  logic [prct_pkg::COUNT_W-1:0]       s_new_count,
    input  logic                               clear_busy,
    input  logic                               q_full,
    output logic                               q_push,
    output prct_pkg::req_t                     q_wdata
);

    localparam int HI_W = prct_pkg::ADDR_W - prct_pkg::PAGE_SHIFT;

    logic [prct_pkg::ADDR_W-1:0] ram_base_reg;
    logic [prct_pkg::ADDR_W-1:0] ram_end_reg;
    logic [prct_pkg::ADDR_W-1:0] diff;
    logic [HI_W-1:0]             frame_wide;
    prct_pkg::cmd_t              cmd;
    logic                        in_range;
    logic                        frame_ok;
    logic                        aligned;
    logic                        need_align;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ram_base_reg <= prct_pkg::RAM_BASE_RST;
            ram_end_reg  <= prct_pkg::RAM_END_RST;
        end else if (cfg_we) begin
            unique case (prct_pkg::cfg_idx_t'(cfg_index))
                prct_pkg::CFG_RAM_BASE: ram_base_reg <= cfg_wdata;
                prct_pkg::CFG_RAM_END:  ram_end_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        cmd        = prct_pkg::cmd_t'(s_cmd);
        diff       = s_addr - ram_base_reg;
        frame_wide = diff[prct_pkg::ADDR_W-1:prct_pkg::PAGE_SHIFT];
        in_range   = (s_addr >= ram_base_reg) && (s_addr < ram_end_reg);
        frame_ok   = frame_wide < HI_W'(prct_pkg::PAGE_COUNT);
        aligned    = s_addr[prct_pkg::PAGE_SHIFT-1:0] == '0;
        need_align = (cmd == prct_pkg::CMD_ACQUIRE) || (cmd == prct_pkg::CMD_RELEASE);

        q_wdata.cmd       = cmd;
        q_wdata.bad       = !(in_range && frame_ok && (aligned || !need_align));
        q_wdata.frame     = frame_wide[prct_pkg::FRAME_W-1:0];
        q_wdata.new_count = s_new_count;
    end

    assign s_tready = !q_full && !clear_busy;
    assign q_push   = s_tvalid && s_tready;

endmodule

/* hdl/prct_fifo.sv */
// Short request queue between the front end and the back end.
// Depends on prct_pkg.
`timescale 1ns / 1ps

module prct_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  prct_pkg::req_t wdata,
    input  logic           pop,
    output prct_pkg::req_t rdata,
    output logic           full,
    output logic           empty
);

    prct_pkg::req_t                 slot_reg [prct_pkg::QUEUE_DEPTH];
    logic [prct_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [prct_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [prct_pkg::QPTR_W:0]      fill_reg;
    logic [prct_pkg::QPTR_W:0]      fill_next;

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = slot_reg[rd_ptr_reg];
    assign full  = fill_reg == (prct_pkg::QPTR_W+1)'(prct_pkg::QUEUE_DEPTH);
    assign empty = fill_reg == '0;

endmodule

/* hdl/prct_back.sv */
// Back end: clears the count memory after reset, then performs one
// read-modify-write per request and holds the result for the output side.
// Depends on prct_pkg and page_reference_counter_table_unit_macros.svh.
`timescale 1ns / 1ps
`include "page_reference_counter_table_unit_macros.svh"

module prct_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_empty,
    input  prct_pkg::req_t               q_rdata,
    output logic                         q_pop,
    output logic                         clear_busy,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [1:0]                   m_status,
    output logic [prct_pkg::COUNT_W-1:0] m_count,
    output logic                         m_page_freed
);

    localparam logic [prct_pkg::FRAME_W-1:0] FRAME_LAST =
        prct_pkg::FRAME_W'(prct_pkg::PAGE_COUNT - 1);

    logic [prct_pkg::COUNT_W-1:0] mem [prct_pkg::PAGE_COUNT];

    prct_pkg::back_state_t        state_reg;
    prct_pkg::back_state_t        state_next;
    logic [prct_pkg::FRAME_W-1:0] clr_idx_reg;
    prct_pkg::req_t               item_reg;
    logic [prct_pkg::COUNT_W-1:0] rd_data_reg;

    logic                         out_valid_reg;
    prct_pkg::status_t            out_status_reg;
    logic [prct_pkg::COUNT_W-1:0] out_count_reg;
    logic                         out_freed_reg;

    logic                         exec_fire;
    logic                         mem_we;
    logic [prct_pkg::FRAME_W-1:0] mem_waddr;
    logic [prct_pkg::COUNT_W-1:0] mem_wdata;

    logic                         upd_en;
    logic [prct_pkg::COUNT_W-1:0] upd_val;
    prct_pkg::status_t            res_status;
    logic [prct_pkg::COUNT_W-1:0] res_count;
    logic                         res_freed;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            prct_pkg::BK_CLEAR: begin
                if (clr_idx_reg == FRAME_LAST) begin
                    state_next = prct_pkg::BK_FETCH;
                end
            end
            prct_pkg::BK_FETCH: begin
                if (!q_empty) begin
                    state_next = prct_pkg::BK_EXEC;
                end
            end
            prct_pkg::BK_EXEC: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = prct_pkg::BK_FETCH;
                end
            end
            default: state_next = prct_pkg::BK_CLEAR;
        endcase
    end

    always_comb begin
        q_pop      = 1'b0;
        exec_fire  = 1'b0;
        clear_busy = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = item_reg.frame;
        mem_wdata  = upd_val;
        unique case (state_reg)
            prct_pkg::BK_CLEAR: begin
                clear_busy = 1'b1;
                mem_we     = 1'b1;
                mem_waddr  = clr_idx_reg;
                mem_wdata  = '0;
            end
            prct_pkg::BK_FETCH: begin
                q_pop = !q_empty;
            end
            prct_pkg::BK_EXEC: begin
                exec_fire = !out_valid_reg || m_tready;
                mem_we    = exec_fire && upd_en;
            end
            default: clear_busy = 1'b1;
        endcase
    end

    always_comb begin
        upd_en     = 1'b0;
        upd_val    = rd_data_reg;
        res_status = prct_pkg::ST_OK;
        res_count  = '0;
        res_freed  = 1'b0;
        if (item_reg.bad) begin
            res_status = prct_pkg::ST_BAD_ADDR;
        end else begin
            unique case (item_reg.cmd)
                prct_pkg::CMD_SET: begin
                    upd_en    = 1'b1;
                    upd_val   = item_reg.new_count;
                    res_count = item_reg.new_count;
                end
                prct_pkg::CMD_GET: begin
                    res_count = rd_data_reg;
                end
                prct_pkg::CMD_ACQUIRE: begin
                    if (rd_data_reg == prct_pkg::COUNT_MAX) begin
                        res_status = prct_pkg::ST_OVERFLOW;
                        res_count  = rd_data_reg;
                    end else begin
                        upd_en    = 1'b1;
                        upd_val   = rd_data_reg + 1'b1;
                        res_count = upd_val;
                    end
                end
                prct_pkg::CMD_RELEASE: begin
                    if (rd_data_reg == '0) begin
                        res_status = prct_pkg::ST_UNDERFLOW;
                    end else begin
                        upd_en    = 1'b1;
                        upd_val   = rd_data_reg - 1'b1;
                        res_count = upd_val;
                        res_freed = upd_val == '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= prct_pkg::BK_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == prct_pkg::BK_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (exec_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_rdata;
        end
        if (exec_fire) begin
            out_status_reg <= res_status;
            out_count_reg  <= res_count;
            out_freed_reg  <= res_freed;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (q_pop) begin
            rd_data_reg <= mem[q_rdata.frame];
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign m_status     = out_status_reg;
    assign m_count      = out_count_reg;
    assign m_page_freed = out_freed_reg;

    `PRCT_ASSERT_SAME(a_no_pop_in_clear, clear_busy, !q_pop, "request taken during clear")
    `PRCT_ASSERT_NEXT(a_pop_then_exec, q_pop, state_reg == prct_pkg::BK_EXEC,
                      "popped request not executed")
    `PRCT_ASSERT_SAME(a_freed_is_zero, out_valid_reg && out_freed_reg,
                      out_status_reg == prct_pkg::ST_OK && out_count_reg == '0,
                      "page freed with nonzero count")
    `PRCT_ASSERT_SAME(a_overflow_max, out_valid_reg && out_status_reg == prct_pkg::ST_OVERFLOW,
                      out_count_reg == prct_pkg::COUNT_MAX, "overflow below maximum count")

endmodule

/* sim/tb_page_reference_counter_table_unit.sv */
// Self-checking testbench for the page reference count table: stream requests in,
// compares every result with a predicted page count table, and sweeps several address windows.
// Depends on prct_pkg and page_reference_counter_table_unit.
`timescale 1ns / 1ps

module tb_page_reference_counter_table_unit;

    import prct_pkg::*;

    typedef struct packed {
        status_t              status;
        logic [COUNT_W-1:0]   count;
        logic                 freed;
    } outcome_t;

    class refcount_scoreboard;
        logic [COUNT_W-1:0] counts [PAGE_COUNT];
        logic [ADDR_W-1:0]  ram_lo;
        logic [ADDR_W-1:0]  ram_top;
        outcome_t           owed [$];
        int unsigned        errors;

        function new();
            foreach (counts[i]) counts[i] = '0;
            ram_lo = RAM_BASE_RST;
            ram_top = RAM_END_RST;
            errors = 0;
        endfunction

        function void set_window(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] top);
            ram_lo = lo;
            ram_top = top;
        endfunction

        function int unsigned pending();
            return owed.size();
        endfunction

        function void note_request(cmd_t cmd, logic [ADDR_W-1:0] addr,
                                   logic [COUNT_W-1:0] value);
            outcome_t           o;
            logic [ADDR_W-1:0]  offset;
            logic [COUNT_W-1:0] cur;
            logic [FRAME_W-1:0] frame;
            bit                 usable;
            o.status = ST_OK;
            o.count = '0;
            o.freed = 1'b0;
            usable = !(addr < ram_lo || addr >= ram_top);
            if ((cmd == CMD_ACQUIRE || cmd == CMD_RELEASE) && addr[PAGE_SHIFT-1:0] != '0) begin
                usable = 1'b0;
            end
            offset = addr - ram_lo;
            if (usable && (offset >> PAGE_SHIFT) >= PAGE_COUNT) begin
                usable = 1'b0;
            end
            frame = FRAME_W'(offset >> PAGE_SHIFT);
            if (!usable) begin
                o.status = ST_BAD_ADDR;
            end else begin
                cur = counts[frame];
                case (cmd)
                    CMD_SET: begin
                        counts[frame] = value;
                        o.count = value;
                    end
                    CMD_GET: begin
                        o.count = cur;
                    end
                    CMD_ACQUIRE: begin
                        if (cur == COUNT_MAX) begin
                            o.status = ST_OVERFLOW;
                            o.count = cur;
                        end else begin
                            counts[frame] = cur + 1'b1;
                            o.count = cur + 1'b1;
                        end
                    end
                    default: begin
                        if (cur == '0) begin
                            o.status = ST_UNDERFLOW;
                        end else begin
                            counts[frame] = cur - 1'b1;
                            o.count = cur - 1'b1;
                            o.freed = (cur == 1);
                        end
                    end
                endcase
            end
            owed.push_back(o);
        endfunction

        function void check_result(logic [23:0] data);
            outcome_t got;
            outcome_t want;
            got.status = status_t'(data[1:0]);
            got.count = data[17:2];
            got.freed = data[18];
            if (owed.size() == 0) begin
                errors++;
                $display("%0t: result with no request pending, got status %0d count %0d freed %0d",
                         $time, data[1:0], got.count, got.freed);
                return;
            end
            want = owed.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: mismatch, expected %0d/%0d/%0d, got %0d/%0d/%0d (status/count/freed)",
                         $time, want.status, want.count, want.freed,
                         data[1:0], got.count, got.freed);
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_RAM_BASE;
    logic [ADDR_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata = '0;
    logic [1:0]           s_tuser = CMD_SET;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [23:0]          m_tdata;

    refcount_scoreboard sb = new();
    bit steady_in = 1'b0;
    bit steady_out = 1'b0;

    page_reference_counter_table_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic send_request(cmd_t cmd, logic [ADDR_W-1:0] addr, logic [COUNT_W-1:0] value);
        int unsigned gap;
        if ($urandom_range(0, 15) == 0) steady_in = !steady_in;
        gap = steady_in ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {value, addr};
        s_tuser <= cmd;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, addr, value);
    endtask

    task automatic write_window(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] top);
        cfg_we <= 1'b1;
        cfg_index <= CFG_RAM_BASE;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_index <= CFG_RAM_END;
        cfg_wdata <= top;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_window(lo, top);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic cmd_t pick_cmd();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 20) return CMD_SET;
        if (r < 35) return CMD_GET;
        if (r < 70) return CMD_ACQUIRE;
        return CMD_RELEASE;
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 16'd1;
            2: return COUNT_MAX - 1'b1;
            3: return COUNT_MAX;
            default: return COUNT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Most addresses land on a handful of pages near both ends of the window so that
    // counts build up; the rest probe the window edges, misalignment and noise.
    function automatic logic [ADDR_W-1:0] pick_addr(cmd_t cmd);
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] a;
        logic [63:0]       r;
        int unsigned       kind;
        int unsigned       f;
        mask = (ADDR_W'(1) << PAGE_SHIFT) - 1'b1;
        first = (sb.ram_lo + mask) & ~mask;
        kind = $urandom_range(0, 99);
        r = {$urandom(), $urandom()};
        if (kind < 72) begin
            f = $urandom_range(0, 7);
            if (f >= 6) f = PAGE_COUNT - 8 + f;
            a = first + (ADDR_W'(f) << PAGE_SHIFT);
            if (cmd == CMD_SET || cmd == CMD_GET) begin
                if ($urandom_range(0, 1) == 1) a = a + (r[ADDR_W-1:0] & mask);
            end else if ($urandom_range(0, 19) == 0) begin
                a = a + ADDR_W'($urandom_range(1, (1 << PAGE_SHIFT) - 1));
            end
        end else if (kind < 78) begin
            a = sb.ram_lo - ADDR_W'($urandom_range(1, 3 << PAGE_SHIFT));
        end else if (kind < 84) begin
            a = sb.ram_top + (ADDR_W'($urandom_range(0, 3)) << PAGE_SHIFT)
                - ADDR_W'($urandom_range(0, 1));
        end else if (kind < 90) begin
            a = first + (ADDR_W'(PAGE_COUNT - 1 + $urandom_range(0, 2)) << PAGE_SHIFT);
        end else begin
            a = r[ADDR_W-1:0];
        end
        return a;
    endfunction

    task automatic run_random(int unsigned n);
        cmd_t cmd;
        for (int unsigned i = 0; i < n; i++) begin
            cmd = pick_cmd();
            send_request(cmd, pick_addr(cmd), pick_count());
        end
    endtask

    initial begin
        int unsigned gap;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 15) == 0) steady_out = !steady_out;
            gap = steady_out ? 0 : $urandom_range(0, 8);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        write_window(RAM_BASE_RST, RAM_END_RST);

        send_request(CMD_GET,     48'h0,         16'h1234);
        send_request(CMD_RELEASE, 48'h0,         16'h0);
        send_request(CMD_ACQUIRE, 48'h0,         16'hFFFF);
        send_request(CMD_RELEASE, 48'h0,         16'h0);
        send_request(CMD_SET,     48'h1FF_FFFF,  COUNT_MAX);
        send_request(CMD_ACQUIRE, 48'h1FF_F000,  16'h0);
        send_request(CMD_GET,     48'h1FF_F800,  16'h0);
        send_request(CMD_SET,     48'h1FF_F000,  16'h1);
        send_request(CMD_RELEASE, 48'h1FF_F000,  16'h0);
        send_request(CMD_SET,     48'h1000,      16'hAAAA);
        send_request(CMD_GET,     48'h1FFF,      16'h0);
        send_request(CMD_SET,     48'h2000,      16'h5555);
        send_request(CMD_ACQUIRE, 48'h1001,      16'h0);
        send_request(CMD_RELEASE, 48'h1FFF,      16'h0);
        send_request(CMD_SET,     48'h3ABC,      16'h0007);
        send_request(CMD_ACQUIRE, 48'h200_0000,  16'h0);
        send_request(CMD_GET,     48'h200_0000,  16'h0);
        send_request(CMD_ACQUIRE, 48'hFFFF_FFFF_F000, 16'h0);
        send_request(CMD_SET,     48'hFFFF_FFFF_FFFF, COUNT_MAX);
        send_request(CMD_GET,     48'h1FF_FFFF,  16'h0);
        run_random(180);
        drain_results();

        write_window(48'hFFFF_0000_0000, 48'hFFFF_FFFF_FFFF);
        run_random(150);
        drain_results();

        write_window(48'h0000_1234_5ABC, 48'h0000_1234_AABC);
        run_random(100);
        drain_results();

        write_window(48'hFFFF_FFFF_F000, 48'hFFFF_FFFF_FFFF);
        run_random(60);
        drain_results();

        write_window(48'h0000_0100_0000, 48'h0000_0000_1000);
        run_random(40);
        drain_results();

        write_window(RAM_BASE_RST, RAM_END_RST);
        run_random(150);
        drain_results();
        repeat (16) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/prct_pkg.sv
hdl/prct_front.sv
hdl/prct_fifo.sv
hdl/prct_back.sv
hdl/page_reference_counter_table_unit.sv
sim/tb_page_reference_counter_table_unit.sv
